@@ sv/oie_pkg.sv @@
// constants and payload types for the override interlock evaluator
package oie_pkg;

	// interlock mask bit positions
	localparam int unsigned ILK_RB_OV     = 0;
	localparam int unsigned ILK_RB_WARM   = 1;
	localparam int unsigned ILK_RELAY     = 2;
	localparam int unsigned ILK_DISP_OFF  = 3;
	localparam int unsigned ILK_WDT       = 4;
	localparam int unsigned ILK_MUX       = 5;
	localparam int unsigned ILK_DAC_PARK  = 6;
	localparam int unsigned ILK_RB_VMAX   = 7;
	localparam int unsigned ILK_FAN_FLOOR = 8;
	localparam int unsigned ILK_TUNNEL    = 9;
	localparam int unsigned ILK_RB_VERIFY = 10;
	localparam int unsigned ILK_COUNT     = 11;

	// status flag bit positions
	localparam int unsigned ST_OV_LATCHED = 0;
	localparam int unsigned ST_OCXO_WARM  = 1;
	localparam int unsigned ST_CAPS_OK    = 2;
	localparam int unsigned ST_RELAY_BLK  = 3;
	localparam int unsigned ST_DISP_ON    = 4;
	localparam int unsigned ST_LIVENESS   = 5;
	localparam int unsigned ST_EXTREF_OK  = 6;
	localparam int unsigned ST_RB_LOCK    = 7;
	localparam int unsigned ST_PARKED     = 8;
	localparam int unsigned ST_COUNT      = 9;

	// failed interlock report codes
	localparam logic [3:0] FAIL_NONE      = 4'd0;
	localparam logic [3:0] FAIL_RB_OV     = 4'd1;
	localparam logic [3:0] FAIL_RB_WARM   = 4'd2;
	localparam logic [3:0] FAIL_RELAY     = 4'd3;
	localparam logic [3:0] FAIL_DISP_OFF  = 4'd4;
	localparam logic [3:0] FAIL_WDT       = 4'd5;
	localparam logic [3:0] FAIL_MUX       = 4'd6;
	localparam logic [3:0] FAIL_DAC_PARK  = 4'd7;
	localparam logic [3:0] FAIL_RB_VMAX   = 4'd8;

	localparam logic [31:0] DISPLAY_MIN_OFF_RESET = 32'd1000;

	localparam int unsigned IN_DATA_W  = 208;
	localparam int unsigned IN_USER_W  = 2;
	localparam int unsigned OUT_DATA_W = 40;

	// request word, lowest field last in the struct so it lands in the low bits
	typedef struct packed {
		logic [4:0]              pad;
		logic [31:0]             display_changed_ms;
		logic [31:0]             now_time_ms;
		logic [6:0]              fan_floor_percent;
		logic [15:0]             voltage_max_mv;
		logic [15:0]             code_window_max;
		logic [15:0]             code_window_min;
		logic [ST_COUNT-1:0]     status_flags;
		logic signed [31:0]      object_minimum;
		logic [ILK_COUNT-1:0]    interlock_mask;
		logic signed [31:0]      requested_value;
	} req_data_t;

	typedef struct packed {
		logic snapshot_valid;
		logic is_code_kind;
	} req_user_t;

	typedef struct packed {
		logic [3:0]         failed_interlock;
		logic               verify_needed;
		logic               tunnel_on;
		logic               was_clamped;
		logic signed [31:0] granted_value;
		logic               refused;
	} res_data_t;

endpackage

@@ sv/override_interlock_evaluator.sv @@
// override interlock evaluator: request register, decision logic, result register
//
// Each word on s_* is one override request; one result word comes out on m_*
// for each, in order. A request is held in the input register and the
// decision (refusal checks in fixed order, then the code-window or voltage
// clamp, then the fan floor) is captured in the output register, from which
// the result is offered, and one request is taken every cycle while
// m_tready is high. s_tready drops only when both registers
// hold words that cannot move. display_min_off_ms is written through cfg_*
// (always ready, reset value 1000) and should be changed only while no request
// is in flight.
module override_interlock_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// requested_value[31:0], interlock_mask[42:32], object_minimum[74:43],
	// status_flags[83:75], code_window_min[99:84], code_window_max[115:100],
	// voltage_max_mv[131:116], fan_floor_percent[138:132],
	// now_time_ms[170:139], display_changed_ms[202:171], zero[207:203]
	input  logic [oie_pkg::IN_DATA_W-1:0] s_tdata,
	// is_code_kind[0], snapshot_valid[1]
	input  logic [oie_pkg::IN_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// refused[0], granted_value[32:1], was_clamped[33], tunnel_on[34],
	// verify_needed[35], failed_interlock[39:36]
	output logic [oie_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [31:0]                   cfg_data
);

	localparam int unsigned ILK_FAIL_W = oie_pkg::ILK_RB_VMAX + 1;

	logic                  valid_s1;
	oie_pkg::req_data_t    data_s1;
	oie_pkg::req_user_t    user_s1;
	logic                  valid_s2;
	oie_pkg::res_data_t    res_s2;
	logic [31:0]           min_off_q;

	logic                  adv_s2;
	logic                  adv_s1;
	oie_pkg::res_data_t    res;

	logic                  nz;
	logic [ILK_FAIL_W-1:0] fail;
	logic [3:0]            lowest_code;
	logic [31:0]           elapsed;
	logic signed [32:0]    lo;
	logic signed [32:0]    hi;
	logic signed [32:0]    v_hi;
	logic signed [32:0]    v_lo;
	logic signed [32:0]    v_fan;
	logic                  clamp_hi;
	logic                  clamp_lo;
	logic                  clamp_fan;
	logic                  window_bad;

	assign adv_s2    = !valid_s2 || m_tready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign s_tready  = adv_s1;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_off_q <= oie_pkg::DISPLAY_MIN_OFF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_off_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= oie_pkg::req_data_t'(s_tdata);
			user_s1 <= oie_pkg::req_user_t'(s_tuser);
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	// refusal conditions, indexed by mask bit
	always_comb begin
		nz      = (data_s1.requested_value != 32'sd0);
		elapsed = data_s1.now_time_ms - data_s1.display_changed_ms;
		if (user_s1.is_code_kind) begin
			lo         = $signed({17'd0, data_s1.code_window_min});
			hi         = $signed({17'd0, data_s1.code_window_max});
			window_bad = (data_s1.code_window_max < data_s1.code_window_min);
		end else begin
			lo         = 33'(data_s1.object_minimum);
			hi         = $signed({17'd0, data_s1.voltage_max_mv});
			window_bad = (data_s1.voltage_max_mv == 16'd0);
		end

		fail[oie_pkg::ILK_RB_OV]    = nz && data_s1.status_flags[oie_pkg::ST_OV_LATCHED];
		fail[oie_pkg::ILK_RB_WARM]  = nz && !(data_s1.status_flags[oie_pkg::ST_OCXO_WARM]
			&& data_s1.status_flags[oie_pkg::ST_CAPS_OK]);
		fail[oie_pkg::ILK_RELAY]    = nz && data_s1.status_flags[oie_pkg::ST_RELAY_BLK];
		fail[oie_pkg::ILK_DISP_OFF] = nz && !data_s1.status_flags[oie_pkg::ST_DISP_ON]
			&& (elapsed < min_off_q);
		fail[oie_pkg::ILK_WDT]      = nz && !data_s1.status_flags[oie_pkg::ST_LIVENESS];
		fail[oie_pkg::ILK_MUX]      = nz && !(data_s1.status_flags[oie_pkg::ST_EXTREF_OK]
			&& data_s1.status_flags[oie_pkg::ST_RB_LOCK]);
		fail[oie_pkg::ILK_DAC_PARK] = !data_s1.status_flags[oie_pkg::ST_PARKED];
		fail[oie_pkg::ILK_RB_VMAX]  = window_bad;
		fail = fail & data_s1.interlock_mask[ILK_FAIL_W-1:0];

		// lowest set mask bit, reported when there is no snapshot
		lowest_code = oie_pkg::FAIL_RB_OV;
		for (int i = int'(oie_pkg::ILK_COUNT) - 1; i >= 0; i--) begin
			if (data_s1.interlock_mask[i]) begin
				lowest_code = 4'(i + 1);
			end
		end
	end

	// clamps: ceiling, then minimum, then fan floor
	always_comb begin
		v_hi     = 33'(data_s1.requested_value);
		clamp_hi = 1'b0;
		clamp_lo = 1'b0;
		if (data_s1.interlock_mask[oie_pkg::ILK_RB_VMAX]) begin
			clamp_hi = (v_hi > hi);
			if (clamp_hi) begin
				v_hi = hi;
			end
		end
		v_lo = v_hi;
		if (data_s1.interlock_mask[oie_pkg::ILK_RB_VMAX]) begin
			clamp_lo = (v_hi < lo);
			if (clamp_lo) begin
				v_lo = lo;
			end
		end
		v_fan     = v_lo;
		clamp_fan = data_s1.interlock_mask[oie_pkg::ILK_FAN_FLOOR]
			&& (v_lo < $signed({26'd0, data_s1.fan_floor_percent}));
		if (clamp_fan) begin
			v_fan = $signed({26'd0, data_s1.fan_floor_percent});
		end
	end

	always_comb begin
		res.refused          = 1'b1;
		res.granted_value    = data_s1.requested_value;
		res.was_clamped      = 1'b0;
		res.tunnel_on        = 1'b0;
		res.verify_needed    = 1'b0;
		res.failed_interlock = oie_pkg::FAIL_NONE;
		if (data_s1.interlock_mask == '0) begin
			res.refused = 1'b0;
		end else if (!user_s1.snapshot_valid) begin
			res.failed_interlock = lowest_code;
		end else if (fail[oie_pkg::ILK_RB_OV]) begin
			res.failed_interlock = oie_pkg::FAIL_RB_OV;
		end else if (fail[oie_pkg::ILK_RB_WARM]) begin
			res.failed_interlock = oie_pkg::FAIL_RB_WARM;
		end else if (fail[oie_pkg::ILK_RELAY]) begin
			res.failed_interlock = oie_pkg::FAIL_RELAY;
		end else if (fail[oie_pkg::ILK_DISP_OFF]) begin
			res.failed_interlock = oie_pkg::FAIL_DISP_OFF;
		end else if (fail[oie_pkg::ILK_WDT]) begin
			res.failed_interlock = oie_pkg::FAIL_WDT;
		end else if (fail[oie_pkg::ILK_MUX]) begin
			res.failed_interlock = oie_pkg::FAIL_MUX;
		end else if (fail[oie_pkg::ILK_DAC_PARK]) begin
			res.failed_interlock = oie_pkg::FAIL_DAC_PARK;
		end else if (fail[oie_pkg::ILK_RB_VMAX]) begin
			res.failed_interlock = oie_pkg::FAIL_RB_VMAX;
		end else begin
			res.refused       = 1'b0;
			res.granted_value = v_fan[31:0];
			res.was_clamped   = clamp_hi || clamp_lo || clamp_fan;
			res.tunnel_on     = nz && data_s1.interlock_mask[oie_pkg::ILK_TUNNEL];
			res.verify_needed = data_s1.interlock_mask[oie_pkg::ILK_RB_VERIFY];
		end
	end

	a_refused_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_s2.refused == (res_s2.failed_interlock != oie_pkg::FAIL_NONE)))
		else $error("refusal flag and failed interlock code disagree");

	a_refused_no_side_effects: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res_s2.refused) |->
		(!res_s2.was_clamped && !res_s2.tunnel_on && !res_s2.verify_needed))
		else $error("refused word carries clamp, tunnel or verify");

	a_word_moves_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> valid_s2)
		else $error("request word lost between input and result register");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2) |-> s_tready)
		else $error("input stalled with a free register");

endmodule

@@ dv/tb_top.sv @@
// testbench for override_interlock_evaluator: request stream, result checks, config writes
`timescale 1ns / 1ps

module tb_top;
	import oie_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int PHASE_ITEMS = 80;

	// expected decisions and the predictor that produces them
	class decision_board;
		res_data_t   pending_decisions[$];
		logic [31:0] min_off_ms = DISPLAY_MIN_OFF_RESET;
		int          mismatches = 0;

		function res_data_t judge(req_data_t d, req_user_t u);
			res_data_t            r;
			longint               v;
			longint               lo;
			longint               hi;
			logic                 nz;
			logic [31:0]          elapsed;
			logic [ST_COUNT-1:0]  st;
			logic [ILK_COUNT-1:0] m;
			int                   b;
			r = '0;
			r.granted_value = d.requested_value;
			m = d.interlock_mask;
			st = d.status_flags;
			nz = (d.requested_value != 0);
			elapsed = d.now_time_ms - d.display_changed_ms;
			v = longint'($signed(d.requested_value));
			if (m == '0)
				return r;
			r.refused = 1'b1;
			// without a snapshot the lowest declared interlock is blamed
			if (!u.snapshot_valid) begin
				for (b = ILK_COUNT - 1; b >= 0; b--)
					if (m[b])
						r.failed_interlock = 4'(b + 1);
				return r;
			end
			if (m[ILK_RB_OV] && st[ST_OV_LATCHED] && nz)
				r.failed_interlock = FAIL_RB_OV;
			else if (m[ILK_RB_WARM] && nz && !(st[ST_OCXO_WARM] && st[ST_CAPS_OK]))
				r.failed_interlock = FAIL_RB_WARM;
			else if (m[ILK_RELAY] && nz && st[ST_RELAY_BLK])
				r.failed_interlock = FAIL_RELAY;
			else if (m[ILK_DISP_OFF] && nz && !st[ST_DISP_ON] && elapsed < min_off_ms)
				r.failed_interlock = FAIL_DISP_OFF;
			else if (m[ILK_WDT] && nz && !st[ST_LIVENESS])
				r.failed_interlock = FAIL_WDT;
			else if (m[ILK_MUX] && nz && !(st[ST_EXTREF_OK] && st[ST_RB_LOCK]))
				r.failed_interlock = FAIL_MUX;
			else if (m[ILK_DAC_PARK] && !st[ST_PARKED])
				r.failed_interlock = FAIL_DAC_PARK;
			else if (m[ILK_RB_VMAX] && (u.is_code_kind ?
					d.code_window_max < d.code_window_min : d.voltage_max_mv == 0))
				r.failed_interlock = FAIL_RB_VMAX;
			if (r.failed_interlock != FAIL_NONE)
				return r;
			r.refused = 1'b0;
			if (m[ILK_RB_VMAX]) begin
				if (u.is_code_kind) begin
					lo = longint'(d.code_window_min);
					hi = longint'(d.code_window_max);
				end else begin
					lo = longint'($signed(d.object_minimum));
					hi = longint'(d.voltage_max_mv);
				end
				// ceiling first, so a minimum above the ceiling wins
				if (v > hi) begin
					v = hi;
					r.was_clamped = 1'b1;
				end
				if (v < lo) begin
					v = lo;
					r.was_clamped = 1'b1;
				end
			end
			if (m[ILK_FAN_FLOOR] && v < longint'(d.fan_floor_percent)) begin
				v = longint'(d.fan_floor_percent);
				r.was_clamped = 1'b1;
			end
			r.granted_value = v[31:0];
			r.tunnel_on = m[ILK_TUNNEL] && nz;
			r.verify_needed = m[ILK_RB_VERIFY];
			return r;
		endfunction

		function void note_request(req_data_t d, req_user_t u);
			pending_decisions.push_back(judge(d, u));
		endfunction

		function void flag(string what, logic signed [63:0] want, logic signed [63:0] got);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", what, want, got);
		endfunction

		function void check_decision(res_data_t got);
			res_data_t want;
			if (pending_decisions.size() == 0) begin
				flag("unexpected result word", 0, 64'(got));
				return;
			end
			want = pending_decisions.pop_front();
			if (got.refused !== want.refused)
				flag("refused", want.refused, got.refused);
			if (got.granted_value !== want.granted_value)
				flag("granted_value", $signed(want.granted_value), $signed(got.granted_value));
			if (got.was_clamped !== want.was_clamped)
				flag("was_clamped", want.was_clamped, got.was_clamped);
			if (got.tunnel_on !== want.tunnel_on)
				flag("tunnel_on", want.tunnel_on, got.tunnel_on);
			if (got.verify_needed !== want.verify_needed)
				flag("verify_needed", want.verify_needed, got.verify_needed);
			if (got.failed_interlock !== want.failed_interlock)
				flag("failed_interlock", want.failed_interlock, got.failed_interlock);
		endfunction

		function void close_out();
			if (pending_decisions.size() != 0)
				flag("results never delivered", 0, pending_decisions.size());
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [IN_USER_W-1:0]   s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [31:0]            cfg_data = '0;

	decision_board board = new();
	bit                    idle_on = 1'b1;
	int                    stall_left = 0;
	int                    quiet_cycles = 0;

	override_interlock_evaluator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result side: check every accepted word, stall in short bursts
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_decision(m_tdata);
		if (stall_left != 0)
			stall_left--;
		else if (idle_on && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 4);
		m_tready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL override_interlock_evaluator");
				$finish;
			end
		end
	end

	function automatic logic [ST_COUNT-1:0] plant_ok();
		logic [ST_COUNT-1:0] st;
		st = '0;
		st[ST_OCXO_WARM] = 1'b1;
		st[ST_CAPS_OK]   = 1'b1;
		st[ST_DISP_ON]   = 1'b1;
		st[ST_LIVENESS]  = 1'b1;
		st[ST_EXTREF_OK] = 1'b1;
		st[ST_RB_LOCK]   = 1'b1;
		st[ST_PARKED]    = 1'b1;
		return st;
	endfunction

	function automatic req_data_t healthy_request();
		req_data_t d;
		d = '0;
		d.requested_value    = 1500;
		d.object_minimum     = -50;
		d.status_flags       = plant_ok();
		d.code_window_min    = 16'd100;
		d.code_window_max    = 16'd4000;
		d.voltage_max_mv     = 16'd3300;
		d.fan_floor_percent  = 7'd20;
		d.now_time_ms        = 50000;
		d.display_changed_ms = 0;
		return d;
	endfunction

	// mostly plausible requests from a healthy plant, some pure noise
	function automatic void make_request(output req_data_t d, output req_user_t u,
			input logic [31:0] min_off);
		bit noise;
		noise = ($urandom_range(0, 9) == 0);
		d = '0;
		d.interlock_mask = ($urandom_range(0, 15) == 0) ? '0 : ILK_COUNT'($urandom);
		case ($urandom_range(0, 5))
			0: d.requested_value = 0;
			1: d.requested_value = $urandom;
			2: d.requested_value = int'($urandom_range(0, 70200)) - 200;
			3: d.requested_value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			4: d.requested_value = $urandom_range(0, 120);
			default: d.requested_value = -int'($urandom_range(1, 1000));
		endcase
		case ($urandom_range(0, 2))
			0: d.object_minimum = int'($urandom_range(0, 1000)) - 500;
			1: d.object_minimum = $urandom;
			default: d.object_minimum = $urandom_range(0, 70000);
		endcase
		d.status_flags = plant_ok();
		d.status_flags[ST_DISP_ON] = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 2) == 0)
			d.status_flags[$urandom_range(0, ST_COUNT - 1)] ^= 1'b1;
		if (noise)
			d.status_flags = ST_COUNT'($urandom);
		d.code_window_min = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 3) == 0)
			d.code_window_max = 16'($urandom_range(0, 65535));
		else if (d.code_window_min > 35535)
			d.code_window_max = 16'($urandom_range(d.code_window_min, 65535));
		else
			d.code_window_max = 16'(d.code_window_min + $urandom_range(0, 30000));
		d.voltage_max_mv = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		d.fan_floor_percent = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127)) :
			7'($urandom_range(0, 100));
		d.now_time_ms = $urandom;
		case ($urandom_range(0, 2))
			0: d.display_changed_ms = $urandom;
			1: d.display_changed_ms = d.now_time_ms - min_off + 1 - $urandom_range(0, 2);
			default: d.display_changed_ms = d.now_time_ms - $urandom_range(0, 2000);
		endcase
		u.is_code_kind = 1'($urandom_range(0, 1));
		u.snapshot_valid = noise ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) != 0);
	endfunction

	task automatic send_request(input req_data_t d, input req_user_t u);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= u;
		do @(posedge clk); while (!s_tready);
		board.note_request(d, u);
	endtask

	// stop sending and let every expected decision come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (board.pending_decisions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_min_off(input logic [31:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.min_off_ms = value;
	endtask

	initial begin
		req_data_t   rq;
		req_user_t   ru;
		logic [31:0] off_times[5];
		int          phase;
		int          i;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty mask passes anything untouched
		ru.is_code_kind = 1'b0;
		ru.snapshot_valid = 1'b0;
		rq = healthy_request();
		rq.requested_value = 32'h7FFF_FFFF;
		send_request(rq, ru);
		rq.requested_value = 32'h8000_0000;
		send_request(rq, ru);

		// no snapshot: lowest declared interlock is reported
		rq.interlock_mask = '1;
		send_request(rq, ru);
		rq.interlock_mask = '0;
		rq.interlock_mask[ILK_TUNNEL] = 1'b1;
		rq.interlock_mask[ILK_RB_VERIFY] = 1'b1;
		send_request(rq, ru);
		rq.interlock_mask[ILK_TUNNEL] = 1'b0;
		send_request(rq, ru);

		ru.snapshot_valid = 1'b1;
		rq = healthy_request();
		rq.interlock_mask[ILK_RB_OV] = 1'b1;
		rq.status_flags[ST_OV_LATCHED] = 1'b1;
		send_request(rq, ru);
		rq.requested_value = 0;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask[ILK_RB_WARM] = 1'b1;
		rq.status_flags[ST_CAPS_OK] = 1'b0;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask[ILK_RELAY] = 1'b1;
		rq.status_flags[ST_RELAY_BLK] = 1'b1;
		send_request(rq, ru);

		// display off time measured across the counter wrap, then exactly at the limit
		rq = healthy_request();
		rq.interlock_mask[ILK_DISP_OFF] = 1'b1;
		rq.status_flags[ST_DISP_ON] = 1'b0;
		rq.now_time_ms = 5;
		rq.display_changed_ms = 32'hFFFF_FFF0;
		send_request(rq, ru);
		rq.display_changed_ms = rq.now_time_ms - DISPLAY_MIN_OFF_RESET;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask[ILK_WDT] = 1'b1;
		rq.status_flags[ST_LIVENESS] = 1'b0;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask[ILK_MUX] = 1'b1;
		rq.status_flags[ST_RB_LOCK] = 1'b0;
		send_request(rq, ru);

		// park check applies even to a zero request
		rq = healthy_request();
		rq.interlock_mask[ILK_DAC_PARK] = 1'b1;
		rq.status_flags[ST_PARKED] = 1'b0;
		rq.requested_value = 0;
		send_request(rq, ru);

		ru.is_code_kind = 1'b1;
		rq = healthy_request();
		rq.interlock_mask[ILK_RB_VMAX] = 1'b1;
		rq.code_window_min = 16'd5000;
		rq.code_window_max = 16'd4999;
		send_request(rq, ru);
		rq.code_window_min = 16'd100;
		rq.code_window_max = 16'hFFFF;
		rq.requested_value = 70000;
		send_request(rq, ru);
		rq.requested_value = -1;
		send_request(rq, ru);

		ru.is_code_kind = 1'b0;
		rq = healthy_request();
		rq.interlock_mask[ILK_RB_VMAX] = 1'b1;
		rq.voltage_max_mv = 16'd0;
		send_request(rq, ru);
		rq.voltage_max_mv = 16'd3300;
		rq.requested_value = 5000;
		send_request(rq, ru);
		rq.object_minimum = 4000;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask[ILK_FAN_FLOOR] = 1'b1;
		rq.fan_floor_percent = 7'h7F;
		rq.requested_value = -5;
		send_request(rq, ru);

		rq = healthy_request();
		rq.interlock_mask = '1;
		rq.requested_value = 1;
		send_request(rq, ru);
		rq.requested_value = 0;
		send_request(rq, ru);

		off_times[0] = 32'd0;
		off_times[1] = 32'hFFFF_FFFF;
		off_times[2] = $urandom;
		off_times[3] = 32'd1;
		off_times[4] = DISPLAY_MIN_OFF_RESET;
		for (phase = 0; phase < 5; phase++) begin
			write_min_off(off_times[phase]);
			for (i = 0; i < PHASE_ITEMS; i++) begin
				// no idling in the final phase, nor in one stretch of each other phase
				idle_on = (phase != 4) && ((i / 20) % 3 != 2);
				make_request(rq, ru, board.min_off_ms);
				send_request(rq, ru);
			end
		end
		wait_drained();

		board.close_out();
		if (board.mismatches == 0)
			$display("PASS override_interlock_evaluator");
		else
			$display("FAIL override_interlock_evaluator");
		$finish;
	end

endmodule

@@ override_interlock_evaluator.f @@
sv/oie_pkg.sv
sv/override_interlock_evaluator.sv
dv/tb_top.sv
